@@ design/music_string_note_parser_top_macros.svh @@
// assertion macros for the music string note parser
`ifndef MUSIC_STRING_NOTE_PARSER_TOP_MACROS_SVH
`define MUSIC_STRING_NOTE_PARSER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MSNP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MSNP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/msnp_pkg.sv @@
// types, character codes and note frequency table for the note parser
`timescale 1ns / 1ps
package msnp_pkg;

   typedef struct packed {
      logic busy;
      logic done;
   } msnp_div_status_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [15:0] TEMPO_DEFAULT = 16'd120;
   localparam logic [31:0] DUR_DEFAULT   = 32'd60000;
   localparam logic [5:0]  PITCH_DEFAULT = 6'd12;
   localparam logic [6:0]  OCT_DEFAULT   = 7'd5;
   localparam logic [9:0]  GAP_DEFAULT   = 10'd10;

   function automatic logic [13:0] freq_rom(input logic [6:0] idx);
      logic [13:0] f;
      unique case (idx)
         7'd0: f = 14'd8;     7'd1: f = 14'd9;     7'd2: f = 14'd9;     7'd3: f = 14'd10;
         7'd4: f = 14'd10;    7'd5: f = 14'd11;    7'd6: f = 14'd12;    7'd7: f = 14'd12;
         7'd8: f = 14'd13;    7'd9: f = 14'd14;    7'd10: f = 14'd15;   7'd11: f = 14'd15;
         7'd12: f = 14'd16;   7'd13: f = 14'd17;   7'd14: f = 14'd18;   7'd15: f = 14'd19;
         7'd16: f = 14'd21;   7'd17: f = 14'd22;   7'd18: f = 14'd23;   7'd19: f = 14'd24;
         7'd20: f = 14'd26;   7'd21: f = 14'd28;   7'd22: f = 14'd29;   7'd23: f = 14'd31;
         7'd24: f = 14'd33;   7'd25: f = 14'd35;   7'd26: f = 14'd37;   7'd27: f = 14'd39;
         7'd28: f = 14'd41;   7'd29: f = 14'd44;   7'd30: f = 14'd46;   7'd31: f = 14'd49;
         7'd32: f = 14'd52;   7'd33: f = 14'd55;   7'd34: f = 14'd58;   7'd35: f = 14'd62;
         7'd36: f = 14'd65;   7'd37: f = 14'd69;   7'd38: f = 14'd73;   7'd39: f = 14'd78;
         7'd40: f = 14'd82;   7'd41: f = 14'd87;   7'd42: f = 14'd92;   7'd43: f = 14'd98;
         7'd44: f = 14'd104;  7'd45: f = 14'd110;  7'd46: f = 14'd117;  7'd47: f = 14'd123;
         7'd48: f = 14'd131;  7'd49: f = 14'd139;  7'd50: f = 14'd147;  7'd51: f = 14'd156;
         7'd52: f = 14'd165;  7'd53: f = 14'd175;  7'd54: f = 14'd185;  7'd55: f = 14'd196;
         7'd56: f = 14'd208;  7'd57: f = 14'd220;  7'd58: f = 14'd233;  7'd59: f = 14'd247;
         7'd60: f = 14'd262;  7'd61: f = 14'd277;  7'd62: f = 14'd294;  7'd63: f = 14'd311;
         7'd64: f = 14'd330;  7'd65: f = 14'd349;  7'd66: f = 14'd370;  7'd67: f = 14'd392;
         7'd68: f = 14'd415;  7'd69: f = 14'd440;  7'd70: f = 14'd466;  7'd71: f = 14'd494;
         7'd72: f = 14'd523;  7'd73: f = 14'd554;  7'd74: f = 14'd587;  7'd75: f = 14'd622;
         7'd76: f = 14'd659;  7'd77: f = 14'd698;  7'd78: f = 14'd740;  7'd79: f = 14'd784;
         7'd80: f = 14'd831;  7'd81: f = 14'd880;  7'd82: f = 14'd932;  7'd83: f = 14'd988;
         7'd84: f = 14'd1047; 7'd85: f = 14'd1109; 7'd86: f = 14'd1175; 7'd87: f = 14'd1245;
         7'd88: f = 14'd1319; 7'd89: f = 14'd1397; 7'd90: f = 14'd1480; 7'd91: f = 14'd1568;
         7'd92: f = 14'd1661; 7'd93: f = 14'd1760; 7'd94: f = 14'd1865; 7'd95: f = 14'd1976;
         7'd96: f = 14'd2093; 7'd97: f = 14'd2217; 7'd98: f = 14'd2349; 7'd99: f = 14'd2489;
         7'd100: f = 14'd2637; 7'd101: f = 14'd2794; 7'd102: f = 14'd2960; 7'd103: f = 14'd3136;
         7'd104: f = 14'd3322; 7'd105: f = 14'd3520; 7'd106: f = 14'd3729; 7'd107: f = 14'd3951;
         7'd108: f = 14'd4186; 7'd109: f = 14'd4435; 7'd110: f = 14'd4699; 7'd111: f = 14'd4978;
         7'd112: f = 14'd5274; 7'd113: f = 14'd5588; 7'd114: f = 14'd5920; 7'd115: f = 14'd6272;
         7'd116: f = 14'd6645; 7'd117: f = 14'd7040; 7'd118: f = 14'd7459; 7'd119: f = 14'd7902;
         7'd120: f = 14'd8372; 7'd121: f = 14'd8870; 7'd122: f = 14'd9397; 7'd123: f = 14'd9956;
         7'd124: f = 14'd10548; 7'd125: f = 14'd11175; 7'd126: f = 14'd11840;
         7'd127: f = 14'd12544;
         default: f = 14'd0;
      endcase
      return f;
   endfunction

endpackage

@@ design/music_string_note_parser_top.sv @@
// music string parser: one request per character, one response per closed token or per zero byte outside a token
`timescale 1ns / 1ps
// A request carries one character of the tune string. A plain character passes through
// the decode and dispatch steps with req_ready low. A duration digit modifier runs a 32-bit
// division by the digit on one serial divider that retires one quotient bit per cycle, once
// for each reading that divides, while req_ready stays low.
// A character that closes a token divides the duration by the tempo while req_ready is low,
// after splitting a numeric pitch and scaling each custom duration still to scale. A zero
// byte outside a token goes through decode and dispatch to the output step. req_ready is
// high only while the parser waits for a character. A response still waiting on rsp_ready
// holds the next closing character or zero byte in the output step until it is taken; other
// characters are not blocked by it.
module music_string_note_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_note_period_ms,
   output logic [31:0] rsp_tone_ms,
   output logic [13:0] rsp_tone_freq_hz,
   output logic        rsp_sounds,
   output logic        rsp_is_rest,
   output logic        rsp_tune_end,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);
   import msnp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECODE   = 7'b0000010,
      S_DISPATCH = 7'b0000100,
      S_NDIV     = 7'b0001000,
      S_RDIV     = 7'b0010000,
      S_PDIV     = 7'b0100000,
      S_OUT      = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_TEMPO = 3'b010,
      PH_TOKEN = 3'b100
   } phase_type;

   typedef enum logic [7:0] {
      ST_PSTART = 8'b00000001,
      ST_ACC    = 8'b00000010,
      ST_OCT0   = 8'b00000100,
      ST_NUM    = 8'b00001000,
      ST_DSTART = 8'b00010000,
      ST_DMOD   = 8'b00100000,
      ST_DCUST  = 8'b01000000,
      ST_DONE   = 8'b10000000
   } step_type;

   typedef struct packed {
      logic num;
      logic ndiv;
      logic rdiv;
      logic nscale;
      logic rscale;
      logic period;
      logic result;
   } pend_type;

   typedef struct packed {
      step_type    step;
      logic [31:0] dur;
      logic        ended;
      logic        div;
      logic        scale;
   } feed_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   step_type    nstep_ff, nstep_in, rstep_ff, rstep_in;
   pend_type    pend_ff, pend_in;
   logic [15:0] tempo_ff, tempo_in, tacc_ff, tacc_in;
   logic [5:0]  cur_pitch_ff, cur_pitch_in, spec_pitch_ff, spec_pitch_in;
   logic [6:0]  cur_oct_ff, cur_oct_in, spec_oct_ff, spec_oct_in;
   logic [9:0]  num_ff, num_in;
   logic [31:0] cur_dur_ff, cur_dur_in, dnote_ff, dnote_in, drest_ff, drest_in;
   logic        rest_flag_ff, rest_flag_in, comma_ff, comma_in;
   logic        end_ff, end_in, blank_ff, blank_in;
   logic [7:0]  char_ff, char_in;
   logic [31:0] period_ff, period_in;
   logic [9:0]  gap_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_period_ff, rsp_period_in, rsp_tone_ff, rsp_tone_in;
   logic [13:0] rsp_freq_ff, rsp_freq_in;
   logic        rsp_snd_ff, rsp_snd_in, rsp_rest_ff, rsp_rest_in, rsp_end_ff, rsp_end_in;

   logic        div_start;
   logic [31:0] div_a, div_q;
   logic [15:0] div_b;
   msnp_div_status_type div_status;
   logic        div_wait;

   logic [31:0] scale_src;
   logic [42:0] scale_prod;
   logic [31:0] scale_res;

   logic [19:0] num_prod;
   logic [6:0]  num_quo;
   logic [9:0]  num_rem;

   feed_type    fr;
   logic [7:0]  c, lc;
   logic        fall, printable;
   logic [19:0] t20;
   logic [13:0] n14;
   logic [31:0] len;
   logic [10:0] npv, npi;
   logic        note_ok, snd;

   msnp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .quotient  (div_q),
      .status    (div_status)
   );

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic [20:0] dur_letter(input logic [7:0] lch);
      logic [20:0] d;
      unique case (lch)
         8'h7A: d = 21'd1920000;
         8'h6C: d = 21'd1440000;
         8'h69: d = 21'd960000;
         8'h75: d = 21'd480000;
         8'h77: d = 21'd240000;
         8'h68: d = 21'd120000;
         8'h71: d = 21'd60000;
         8'h65: d = 21'd30000;
         8'h73: d = 21'd15000;
         8'h74: d = 21'd7500;
         8'h78: d = 21'd3750;
         8'h6F: d = 21'd1875;
         default: d = 21'd0;
      endcase
      return d;
   endfunction

   function automatic logic [5:0] pitch_letter(input logic [7:0] lch);
      logic [5:0] p;
      unique case (lch)
         8'h63: p = 6'd12;
         8'h64: p = 6'd14;
         8'h65: p = 6'd16;
         8'h66: p = 6'd17;
         8'h67: p = 6'd19;
         8'h61: p = 6'd21;
         8'h62: p = 6'd23;
         default: p = 6'd0;
      endcase
      return p;
   endfunction

   // one step of a duration reading; division and scaling are left to the sequencer
   function automatic feed_type dur_feed(input step_type s, input logic [31:0] d,
                                         input logic [7:0] ch);
      feed_type    r;
      logic [7:0]  lch;
      logic [32:0] v;
      logic [35:0] m;
      lch     = ch | CH_SPACE;
      r.step  = s;
      r.dur   = d;
      r.ended = 1'b0;
      r.div   = 1'b0;
      r.scale = 1'b0;
      v       = 33'd0;
      m       = 36'd0;
      priority case (s)
         ST_DSTART: begin
            if (lch == 8'h64) begin
               r.dur  = 32'd0;
               r.step = ST_DCUST;
            end else if (dur_letter(lch) != 21'd0) begin
               r.dur  = {11'd0, dur_letter(lch)};
               r.step = ST_DMOD;
            end else begin
               r.step  = ST_DONE;
               r.ended = 1'b1;
            end
         end
         ST_DMOD: begin
            if (ch >= CH_ONE && ch <= CH_NINE) begin
               r.div = 1'b1;
            end else if (ch == CH_DOT || ch == CH_COLON) begin
               v = {1'b0, d} + ((ch == CH_DOT) ? {2'b0, d[31:1]} : {1'b0, d});
               r.dur = v[32] ? 32'hFFFF_FFFF : v[31:0];
            end else begin
               r.step  = ST_DONE;
               r.ended = 1'b1;
            end
         end
         ST_DCUST: begin
            if (is_digit(ch)) begin
               m = {1'b0, d, 3'b000} + {3'b000, d, 1'b0} + {32'd0, ch[3:0]};
               r.dur = (m[35:32] != 4'd0) ? 32'hFFFF_FFFF : m[31:0];
            end else begin
               r.scale = 1'b1;
               r.step  = ST_DONE;
               r.ended = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // shared scaler for custom durations: d * 1875 / 2, saturating
   assign scale_src  = pend_ff.nscale ? dnote_ff : drest_ff;
   assign scale_prod = {11'd0, scale_src} * 43'd1875;
   assign scale_res  = (scale_prod[42:33] != 10'd0) ? 32'hFFFF_FFFF : scale_prod[32:1];

   // note number split into octave and pitch, 683 / 8192 stands in for 1 / 12
   assign num_prod = {10'd0, num_ff} * 20'd683;
   assign num_quo  = num_prod[19:13];
   assign num_rem  = num_ff - ({num_quo, 3'b000} + {1'b0, num_quo, 2'b00});

   // result fields
   assign len     = comma_ff ? {1'b0, period_ff[31:1]} : period_ff;
   assign npv     = {1'b0, cur_oct_ff, 3'b000} + {2'b00, cur_oct_ff, 2'b00}
                    + {5'd0, cur_pitch_ff};
   assign npi     = npv - 11'd12;
   assign note_ok = (npv > 11'd12) && (npv < 11'd140);
   assign snd     = !rest_flag_ff && (len > {22'd0, gap_ff}) && note_ok;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      nstep_in      = nstep_ff;
      rstep_in      = rstep_ff;
      pend_in       = pend_ff;
      tempo_in      = tempo_ff;
      tacc_in       = tacc_ff;
      cur_pitch_in  = cur_pitch_ff;
      cur_oct_in    = cur_oct_ff;
      spec_pitch_in = spec_pitch_ff;
      spec_oct_in   = spec_oct_ff;
      num_in        = num_ff;
      cur_dur_in    = cur_dur_ff;
      dnote_in      = dnote_ff;
      drest_in      = drest_ff;
      rest_flag_in  = rest_flag_ff;
      comma_in      = comma_ff;
      end_in        = end_ff;
      blank_in      = blank_ff;
      char_in       = char_ff;
      period_in     = period_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_period_in = rsp_period_ff;
      rsp_tone_in   = rsp_tone_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_snd_in    = rsp_snd_ff;
      rsp_rest_in   = rsp_rest_ff;
      rsp_end_in    = rsp_end_ff;
      div_start     = 1'b0;
      div_a         = dnote_ff;
      div_b         = {12'd0, char_ff[3:0]};
      c             = char_ff;
      lc            = char_ff | CH_SPACE;
      printable     = (char_ff > CH_SPACE) && (char_ff < CH_DEL);
      fall          = 1'b0;
      fr            = '0;
      t20           = {1'b0, tacc_ff, 3'b000} + {3'b000, tacc_ff, 1'b0} + {16'd0, char_ff[3:0]};
      n14           = {1'b0, num_ff, 3'b000} + {3'b000, num_ff, 1'b0} + {10'd0, char_ff[3:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in  = req_char_code;
               pend_in  = '0;
               end_in   = 1'b0;
               blank_in = 1'b0;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_DISPATCH;
            if (phase_ff == PH_TOKEN && !printable) begin
               // token closes
               pend_in.num    = (nstep_ff == ST_NUM);
               pend_in.nscale = (nstep_ff == ST_DCUST);
               pend_in.rscale = (rstep_ff == ST_DCUST);
               pend_in.period = 1'b1;
               pend_in.result = 1'b1;
               end_in         = (c == CH_NUL);
               phase_in       = PH_IDLE;
            end else if (phase_ff == PH_TEMPO && is_digit(c)) begin
               tacc_in = (t20[19:16] != 4'd0) ? 16'hFFFF : t20[15:0];
            end else begin
               if (phase_ff == PH_TEMPO) begin
                  tempo_in = (tacc_ff != 16'd0) ? tacc_ff : TEMPO_DEFAULT;
                  phase_in = PH_IDLE;
               end
               if (phase_ff != PH_TOKEN) begin
                  if (c == CH_NUL) begin
                     pend_in.result = 1'b1;
                     end_in         = 1'b1;
                     blank_in       = 1'b1;
                  end else if (c == CH_PERCENT) begin
                     tacc_in  = 16'd0;
                     phase_in = PH_TEMPO;
                  end else if (!printable) begin
                     phase_in = PH_IDLE;
                  end else begin
                     // token opens on this character
                     phase_in      = PH_TOKEN;
                     rest_flag_in  = 1'b0;
                     comma_in      = 1'b0;
                     nstep_in      = ST_PSTART;
                     rstep_in      = ST_DSTART;
                     spec_pitch_in = cur_pitch_ff;
                     spec_oct_in   = cur_oct_ff;
                     dnote_in      = cur_dur_ff;
                     drest_in      = cur_dur_ff;
                  end
               end
               if (phase_in == PH_TOKEN) begin
                  if (lc == 8'h72) rest_flag_in = 1'b1;
                  // note reading
                  unique case (nstep_in)
                     ST_PSTART: begin
                        if (pitch_letter(lc) != 6'd0) begin
                           spec_pitch_in = pitch_letter(lc);
                           nstep_in      = ST_ACC;
                        end else if (lc == 8'h6D || lc == 8'h6E || lc == 8'h70
                                     || c == CH_DOLLAR) begin
                           num_in   = 10'd0;
                           nstep_in = ST_NUM;
                        end else begin
                           nstep_in = ST_DSTART;
                           fall     = 1'b1;
                        end
                     end
                     ST_ACC: begin
                        if (lc == 8'h62) begin
                           if (spec_pitch_in != 6'd0) spec_pitch_in = spec_pitch_in - 6'd1;
                        end else if (c == CH_HASH) begin
                           if (spec_pitch_in < 6'd36) spec_pitch_in = spec_pitch_in + 6'd1;
                        end else if (is_digit(c)) begin
                           spec_oct_in = {3'd0, c[3:0]} + 7'd1;
                           nstep_in    = (c == CH_ZERO) ? ST_OCT0 : ST_DSTART;
                        end else begin
                           nstep_in = ST_DSTART;
                           fall     = 1'b1;
                        end
                     end
                     ST_OCT0: begin
                        nstep_in = ST_DSTART;
                        if (c == CH_ZERO) spec_oct_in = 7'd0;
                        else fall = 1'b1;
                     end
                     ST_NUM: begin
                        if (is_digit(c)) begin
                           num_in = (n14 > 14'd1023) ? 10'd1023 : n14[9:0];
                        end else begin
                           pend_in.num = 1'b1;
                           nstep_in    = ST_DSTART;
                           fall        = 1'b1;
                        end
                     end
                     ST_DSTART, ST_DMOD, ST_DCUST, ST_DONE: begin
                        fall = 1'b1;
                     end
                  endcase
                  if (fall) begin
                     fr             = dur_feed(nstep_in, dnote_in, c);
                     nstep_in       = fr.step;
                     dnote_in       = fr.dur;
                     pend_in.ndiv   = fr.div;
                     pend_in.nscale = fr.scale;
                     if (fr.ended && c == CH_COMMA) comma_in = 1'b1;
                  end
                  // rest reading
                  fr             = dur_feed(rstep_in, drest_in, c);
                  rstep_in       = fr.step;
                  drest_in       = fr.dur;
                  pend_in.rdiv   = fr.div;
                  pend_in.rscale = fr.scale;
               end
            end
         end

         S_DISPATCH: begin
            priority if (pend_ff.num) begin
               pend_in.num   = 1'b0;
               spec_oct_in   = num_quo;
               spec_pitch_in = num_rem[5:0] + 6'd12;
            end else if (pend_ff.ndiv) begin
               pend_in.ndiv = 1'b0;
               div_start    = 1'b1;
               div_a        = dnote_ff;
               state_in     = S_NDIV;
            end else if (pend_ff.rdiv) begin
               pend_in.rdiv = 1'b0;
               div_start    = 1'b1;
               div_a        = drest_ff;
               state_in     = S_RDIV;
            end else if (pend_ff.nscale) begin
               pend_in.nscale = 1'b0;
               dnote_in       = scale_res;
            end else if (pend_ff.rscale) begin
               pend_in.rscale = 1'b0;
               drest_in       = scale_res;
            end else if (pend_ff.period) begin
               pend_in.period = 1'b0;
               div_start      = 1'b1;
               div_a          = rest_flag_ff ? drest_ff : dnote_ff;
               div_b          = tempo_ff;
               cur_dur_in     = div_a;
               if (!rest_flag_ff) begin
                  cur_pitch_in = spec_pitch_ff;
                  cur_oct_in   = spec_oct_ff;
               end
               state_in = S_PDIV;
            end else if (pend_ff.result) begin
               state_in = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_NDIV: begin
            if (div_status.done) begin
               dnote_in = div_q;
               state_in = S_DISPATCH;
            end
         end

         S_RDIV: begin
            if (div_status.done) begin
               drest_in = div_q;
               state_in = S_DISPATCH;
            end
         end

         S_PDIV: begin
            if (div_status.done) begin
               period_in = div_q;
               state_in  = S_DISPATCH;
            end
         end

         S_OUT: begin
            // hold here while the previous response is still waiting
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_end_in     = end_ff;
               pend_in.result = 1'b0;
               if (blank_ff) begin
                  rsp_period_in = 32'd0;
                  rsp_tone_in   = 32'd0;
                  rsp_freq_in   = 14'd0;
                  rsp_snd_in    = 1'b0;
                  rsp_rest_in   = 1'b0;
               end else begin
                  rsp_period_in = period_ff;
                  rsp_tone_in   = snd ? (len - {22'd0, gap_ff}) : 32'd0;
                  rsp_freq_in   = snd ? freq_rom(npi[6:0]) : 14'd0;
                  rsp_snd_in    = snd;
                  rsp_rest_in   = rest_flag_ff;
               end
               if (end_ff) begin
                  phase_in      = PH_IDLE;
                  tempo_in      = TEMPO_DEFAULT;
                  tacc_in       = 16'd0;
                  cur_pitch_in  = PITCH_DEFAULT;
                  cur_oct_in    = OCT_DEFAULT;
                  spec_pitch_in = PITCH_DEFAULT;
                  spec_oct_in   = OCT_DEFAULT;
                  num_in        = 10'd0;
                  cur_dur_in    = DUR_DEFAULT;
                  dnote_in      = DUR_DEFAULT;
                  drest_in      = DUR_DEFAULT;
                  rest_flag_in  = 1'b0;
                  comma_in      = 1'b0;
                  nstep_in      = ST_PSTART;
                  rstep_in      = ST_DSTART;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_IDLE;
         nstep_ff      <= ST_PSTART;
         rstep_ff      <= ST_DSTART;
         pend_ff       <= '0;
         tempo_ff      <= TEMPO_DEFAULT;
         tacc_ff       <= 16'd0;
         cur_pitch_ff  <= PITCH_DEFAULT;
         cur_oct_ff    <= OCT_DEFAULT;
         spec_pitch_ff <= PITCH_DEFAULT;
         spec_oct_ff   <= OCT_DEFAULT;
         num_ff        <= 10'd0;
         cur_dur_ff    <= DUR_DEFAULT;
         dnote_ff      <= DUR_DEFAULT;
         drest_ff      <= DUR_DEFAULT;
         rest_flag_ff  <= 1'b0;
         comma_ff      <= 1'b0;
         end_ff        <= 1'b0;
         blank_ff      <= 1'b0;
         gap_ff        <= GAP_DEFAULT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         nstep_ff      <= nstep_in;
         rstep_ff      <= rstep_in;
         pend_ff       <= pend_in;
         tempo_ff      <= tempo_in;
         tacc_ff       <= tacc_in;
         cur_pitch_ff  <= cur_pitch_in;
         cur_oct_ff    <= cur_oct_in;
         spec_pitch_ff <= spec_pitch_in;
         spec_oct_ff   <= spec_oct_in;
         num_ff        <= num_in;
         cur_dur_ff    <= cur_dur_in;
         dnote_ff      <= dnote_in;
         drest_ff      <= drest_in;
         rest_flag_ff  <= rest_flag_in;
         comma_ff      <= comma_in;
         end_ff        <= end_in;
         blank_ff      <= blank_in;
         if (csr_wr_en) gap_ff <= csr_wr_data;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_ff       <= char_in;
      period_ff     <= period_in;
      rsp_period_ff <= rsp_period_in;
      rsp_tone_ff   <= rsp_tone_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_snd_ff    <= rsp_snd_in;
      rsp_rest_ff   <= rsp_rest_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_note_period_ms = rsp_period_ff;
   assign rsp_tone_ms        = rsp_tone_ff;
   assign rsp_tone_freq_hz   = rsp_freq_ff;
   assign rsp_sounds         = rsp_snd_ff;
   assign rsp_is_rest        = rsp_rest_ff;
   assign rsp_tune_end       = rsp_end_ff;

   assign div_wait = (state_ff == S_NDIV) || (state_ff == S_RDIV) || (state_ff == S_PDIV);

`include "music_string_note_parser_top_macros.svh"

   `MSNP_ASSERT_NOW(a_ready_div_quiet, req_ready, !div_status.busy, "divider busy while ready")
   `MSNP_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == S_DECODE, "request not decoded")
   `MSNP_ASSERT_NOW(a_done_in_wait, div_status.done, div_wait, "divider result unused")

endmodule

@@ design/msnp_div.sv @@
// iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
`timescale 1ns / 1ps
module msnp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [31:0]                  dividend,
   input  logic [15:0]                  divisor,
   output logic [31:0]                  quotient,
   output msnp_pkg::msnp_div_status_type status
);
   import msnp_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;
   logic [17:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[31]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = 16'd0;
         dvs_in = divisor;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         rem_in = diff[17] ? shifted[15:0] : diff[15:0];
         quo_in = {quo_ff[30:0], ~diff[17]};
         cnt_in = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (cnt_ff != 6'd0);
   assign status.done = done_ff;

endmodule
